// ===== design/assert_macros.svh =====
// assertion macros shared by the sliding window event counter rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWEC_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, sampled on clk, off during reset
`define SWEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== design/swec_pkg.sv =====
// types and constants of the sliding window event counter
// no dependencies; used by the interfaces and the top module
package swec_pkg;

    // widths fixed by the request and result formats
    localparam int TS_W    = 31;
    localparam int COUNT_W = 8;

    // reset value of the window length register
    localparam logic [TS_W-1:0] WINDOW_RESET = 31'd3000;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

// ===== design/swec_if.sv =====
// handshake channels of the sliding window event counter
// depends on swec_pkg for field widths
interface swec_evt_if;
    logic                          valid;
    logic                          ready;
    logic [swec_pkg::TS_W-1:0]     timestamp;

    modport source (output valid, output timestamp, input ready);
    modport sink   (input valid, input timestamp, output ready);
endinterface

interface swec_res_if;
    logic                          valid;
    logic                          ready;
    logic [swec_pkg::COUNT_W-1:0]  recent_count;
    logic                          overflow;

    modport source (output valid, output recent_count, output overflow, input ready);
    modport sink   (input valid, input recent_count, input overflow, output ready);
endinterface

interface swec_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [swec_pkg::TS_W-1:0]     window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

// ===== design/swec_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module swec_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/sliding_window_event_counter_top.sv =====
// Sliding window event counter: each request carries a timestamp that is
// appended to a ring buffer of STORE_DEPTH entries; entries are then dropped
// from the oldest end while oldest + window_length < timestamp, and the
// result gives the number of held entries (overflow set, state untouched,
// when the buffer was already full). A request is accepted in ST_IDLE; in
// ST_CMP the older entries are then compared one at a time from the oldest,
// each dropped entry being followed by a compare of the next one, until an
// entry is kept or only the new entry is left (no compare at all when the
// buffer was empty or full); the result is then held in ST_DONE until the
// receiver takes it, and no new request is taken before that. All compares
// go through the single compare unit fed through the one read port of the
// timestamp ram. window_length writes are taken any cycle.
// Depends on swec_pkg, swec_if, swec_ram and assert_macros.svh.
`include "assert_macros.svh"

module sliding_window_event_counter_top #(
    parameter int STORE_DEPTH = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    swec_evt_if.sink     evt_in,
    swec_res_if.source   res_out,
    swec_cfg_if.sink     cfg
);

    localparam int PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int TS_W  = swec_pkg::TS_W;

    swec_pkg::state_t   state_reg, state_next;
    logic [PTR_W-1:0]   oldest_reg, oldest_next;
    logic [PTR_W-1:0]   newest_reg, newest_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TS_W-1:0]    ts_reg, ts_next;
    logic               ovf_reg, ovf_next;
    logic [TS_W-1:0]    win_reg;

    logic               ram_we;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_raddr;
    logic [TS_W-1:0]    ram_rdata;
    logic               is_full;
    logic               drop;
    logic [TS_W:0]      limit;
    logic [CNT_W+7:0]   count_ext;
    logic [PTR_W-1:0]   oldest_inc;
    logic [PTR_W-1:0]   newest_inc;

    // timestamp ring buffer
    swec_ram #(
        .WIDTH (TS_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (newest_reg),
        .wdata (evt_in.timestamp),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ring pointer increments
    assign oldest_inc = (oldest_reg == PTR_W'(STORE_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    assign newest_inc = (newest_reg == PTR_W'(STORE_DEPTH - 1)) ? '0 : newest_reg + 1'b1;

    // shared compare unit: oldest + window < new timestamp
    assign limit   = {1'b0, ram_rdata} + {1'b0, win_reg};
    assign drop    = limit < {1'b0, ts_reg};
    assign is_full = count_reg == CNT_W'(STORE_DEPTH);

    // result payload
    assign count_ext            = {8'd0, count_reg};
    assign res_out.recent_count = count_ext[7:0];
    assign res_out.overflow     = ovf_reg;

    // configuration port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= swec_pkg::WINDOW_RESET;
        end
        else if (cfg.valid)
        begin
            win_reg <= cfg.window_length;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= swec_pkg::ST_IDLE;
            oldest_reg <= '0;
            newest_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            newest_reg <= newest_next;
            count_reg  <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ts_reg  <= ts_next;
        ovf_reg <= ovf_next;
    end

    // sequencer: next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        oldest_next   = oldest_reg;
        newest_next   = newest_reg;
        count_next    = count_reg;
        ts_next       = ts_reg;
        ovf_next      = ovf_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = oldest_reg;
        evt_in.ready  = 1'b0;
        res_out.valid = 1'b0;
        unique case (state_reg)
            swec_pkg::ST_IDLE:
            begin
                evt_in.ready = 1'b1;
                if (evt_in.valid)
                begin
                    ts_next = evt_in.timestamp;
                    if (is_full)
                    begin
                        ovf_next   = 1'b1;
                        state_next = swec_pkg::ST_DONE;
                    end
                    else
                    begin
                        ovf_next    = 1'b0;
                        ram_we      = 1'b1;
                        newest_next = newest_inc;
                        count_next  = count_reg + 1'b1;
                        if (count_reg == '0)
                        begin
                            // the new entry alone is never dropped
                            state_next = swec_pkg::ST_DONE;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = swec_pkg::ST_CMP;
                        end
                    end
                end
            end
            swec_pkg::ST_CMP:
            begin
                if (drop)
                begin
                    oldest_next = oldest_inc;
                    count_next  = count_reg - 1'b1;
                    if (count_reg == CNT_W'(2))
                    begin
                        // only the new entry is left
                        state_next = swec_pkg::ST_DONE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = oldest_inc;
                    end
                end
                else
                begin
                    state_next = swec_pkg::ST_DONE;
                end
            end
            swec_pkg::ST_DONE:
            begin
                res_out.valid = 1'b1;
                if (res_out.ready)
                begin
                    state_next = swec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swec_pkg::ST_IDLE;
            end
        endcase
    end

    // held count never exceeds the buffer depth
    `SWEC_ASSERT(a_count_bound, 1'b1, count_reg <= CNT_W'(STORE_DEPTH))
    // a compare step always has the new entry plus at least one older one
    `SWEC_ASSERT(a_cmp_two_held, state_reg == swec_pkg::ST_CMP, count_reg >= CNT_W'(2))
    // overflow is only reported with a full buffer
    `SWEC_ASSERT(a_ovf_full, res_out.valid && res_out.overflow, is_full)
    // an accepted request into a non-full buffer grows the count by one
    `SWEC_ASSERT_NEXT(a_push_count, evt_in.valid && evt_in.ready && !is_full,
        count_reg == $past(count_reg) + 1'b1)

endmodule
